// ===== sv/ipd_pkg.sv =====
// Shared constants, types and helpers of the infrared pulse-distance frame sender.
package ipd_pkg;

    // Frame and timing sizes
    localparam int FRAME_BITS    = 40;
    localparam int TICK_BITS     = 10;
    localparam int LEN_BITS      = 10;
    localparam int BYTE_BITS     = 8;
    localparam int BIT_IDX_BITS  = $clog2(FRAME_BITS + 1);
    localparam int CMP_BITS      = (TICK_BITS + 1 > LEN_BITS) ? TICK_BITS + 1 : LEN_BITS;

    // Configuration port sizes
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
    localparam int PADDR_BITS    = REG_IDX_BITS + 2;
    localparam int PDATA_BITS    = 32;

    // Register reset values
    localparam logic [BYTE_BITS-1:0] RST_ADDRESS_LOW        = 8'd3;
    localparam logic [BYTE_BITS-1:0] RST_ADDRESS_HIGH       = 8'd252;
    localparam logic [BYTE_BITS-1:0] RST_TRAILER_BYTE       = 8'h66;
    localparam logic [LEN_BITS-1:0]  RST_LEADER_MARK_TICKS  = 10'd684;
    localparam logic [LEN_BITS-1:0]  RST_LEADER_SPACE_TICKS = 10'd342;
    localparam logic [LEN_BITS-1:0]  RST_BIT_MARK_TICKS     = 10'd42;
    localparam logic [LEN_BITS-1:0]  RST_ZERO_SPACE_TICKS   = 10'd43;
    localparam logic [LEN_BITS-1:0]  RST_ONE_SPACE_TICKS    = 10'd128;

    // Input command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_ADDRESS_LOW,
        REG_ADDRESS_HIGH,
        REG_TRAILER_BYTE,
        REG_LEADER_MARK_TICKS,
        REG_LEADER_SPACE_TICKS,
        REG_BIT_MARK_TICKS,
        REG_ZERO_SPACE_TICKS,
        REG_ONE_SPACE_TICKS
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_BITS-1:0] address_low;
        logic [BYTE_BITS-1:0] address_high;
        logic [BYTE_BITS-1:0] trailer_byte;
        logic [LEN_BITS-1:0]  leader_mark_ticks;
        logic [LEN_BITS-1:0]  leader_space_ticks;
        logic [LEN_BITS-1:0]  bit_mark_ticks;
        logic [LEN_BITS-1:0]  zero_space_ticks;
        logic [LEN_BITS-1:0]  one_space_ticks;
    } t_cfg;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } t_result;

    // Assemble the frame: address low, address high, command, inverted command, trailer
    function automatic logic [FRAME_BITS-1:0] build_frame(
        input logic [BYTE_BITS-1:0] addr_lo,
        input logic [BYTE_BITS-1:0] addr_hi,
        input logic [BYTE_BITS-1:0] cmd_byte,
        input logic [BYTE_BITS-1:0] trailer
    );
        logic [63:0] w;
        w = {24'd0, trailer, ~cmd_byte, cmd_byte, addr_hi, addr_lo};
        return w[FRAME_BITS-1:0];
    endfunction

endpackage

// ===== sv/ipd_intf.sv =====
// Handshake channels for input items and result items.
interface ipd_item_if;
    import ipd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [BYTE_BITS-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface ipd_result_if;
    logic valid;
    logic ready;
    logic carrier_on;
    logic busy_res;
    logic accepted;
    logic frame_done;

    modport source (output valid, output carrier_on, output busy_res, output accepted,
                    output frame_done, input ready);
    modport sink   (input valid, input carrier_on, input busy_res, input accepted,
                    input frame_done, output ready);
endinterface

// ===== sv/ipd_cfg_regs.sv =====
// APB-style configuration register bank.
module ipd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipd_pkg::PADDR_BITS-1:0] paddr,
    input  logic [ipd_pkg::PDATA_BITS-1:0] pwdata,
    output logic [ipd_pkg::PDATA_BITS-1:0] prdata,
    output logic                          pready,
    output ipd_pkg::t_cfg                 o_cfg
);
    import ipd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Write the addressed register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_low        <= RST_ADDRESS_LOW;
            r_cfg.address_high       <= RST_ADDRESS_HIGH;
            r_cfg.trailer_byte       <= RST_TRAILER_BYTE;
            r_cfg.leader_mark_ticks  <= RST_LEADER_MARK_TICKS;
            r_cfg.leader_space_ticks <= RST_LEADER_SPACE_TICKS;
            r_cfg.bit_mark_ticks     <= RST_BIT_MARK_TICKS;
            r_cfg.zero_space_ticks   <= RST_ZERO_SPACE_TICKS;
            r_cfg.one_space_ticks    <= RST_ONE_SPACE_TICKS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ADDRESS_LOW:        r_cfg.address_low        <= pwdata[BYTE_BITS-1:0];
                REG_ADDRESS_HIGH:       r_cfg.address_high       <= pwdata[BYTE_BITS-1:0];
                REG_TRAILER_BYTE:       r_cfg.trailer_byte       <= pwdata[BYTE_BITS-1:0];
                REG_LEADER_MARK_TICKS:  r_cfg.leader_mark_ticks  <= pwdata[LEN_BITS-1:0];
                REG_LEADER_SPACE_TICKS: r_cfg.leader_space_ticks <= pwdata[LEN_BITS-1:0];
                REG_BIT_MARK_TICKS:     r_cfg.bit_mark_ticks     <= pwdata[LEN_BITS-1:0];
                REG_ZERO_SPACE_TICKS:   r_cfg.zero_space_ticks   <= pwdata[LEN_BITS-1:0];
                REG_ONE_SPACE_TICKS:    r_cfg.one_space_ticks    <= pwdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            REG_ADDRESS_LOW:        prdata = PDATA_BITS'(r_cfg.address_low);
            REG_ADDRESS_HIGH:       prdata = PDATA_BITS'(r_cfg.address_high);
            REG_TRAILER_BYTE:       prdata = PDATA_BITS'(r_cfg.trailer_byte);
            REG_LEADER_MARK_TICKS:  prdata = PDATA_BITS'(r_cfg.leader_mark_ticks);
            REG_LEADER_SPACE_TICKS: prdata = PDATA_BITS'(r_cfg.leader_space_ticks);
            REG_BIT_MARK_TICKS:     prdata = PDATA_BITS'(r_cfg.bit_mark_ticks);
            REG_ZERO_SPACE_TICKS:   prdata = PDATA_BITS'(r_cfg.zero_space_ticks);
            REG_ONE_SPACE_TICKS:    prdata = PDATA_BITS'(r_cfg.one_space_ticks);
            default:                prdata = '0;
        endcase
    end

endmodule

// ===== sv/ipd_frame_core.sv =====
// Frame sequencer: phase, tick counter, bit index and frame shift register.
module ipd_frame_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_command,
    input  logic [ipd_pkg::BYTE_BITS-1:0] i_data_byte,
    input  ipd_pkg::t_cfg                i_cfg,
    output ipd_pkg::t_result             o_result
);
    import ipd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_CLOSE
    } t_phase;

    t_phase                  r_phase,   n_phase;
    logic [TICK_BITS-1:0]    r_cnt,     n_cnt;
    logic [BIT_IDX_BITS-1:0] r_bit,     n_bit;
    logic [FRAME_BITS-1:0]   r_shift,   n_shift;
    logic                    r_carrier, n_carrier;

    logic                    busy;
    logic [TICK_BITS:0]      next_cnt;
    logic [LEN_BITS-1:0]     phase_len;
    logic                    phase_end;
    logic [BIT_IDX_BITS:0]   next_bit;
    logic                    acc;
    logic                    done;

    assign busy     = (r_phase != PH_IDLE);
    assign next_cnt = {1'b0, r_cnt} + 1'b1;
    assign next_bit = {1'b0, r_bit} + 1'b1;

    // Pick the length of the current phase, read live from the registers
    always_comb begin
        case (r_phase)
            PH_LEAD_MARK:  phase_len = i_cfg.leader_mark_ticks;
            PH_LEAD_SPACE: phase_len = i_cfg.leader_space_ticks;
            PH_BIT_MARK:   phase_len = i_cfg.bit_mark_ticks;
            PH_BIT_SPACE:  phase_len = r_shift[0] ? i_cfg.one_space_ticks
                                                  : i_cfg.zero_space_ticks;
            PH_CLOSE:      phase_len = i_cfg.bit_mark_ticks;
            default:       phase_len = LEN_BITS'(1);
        endcase
    end

    // A phase ends once the counter reaches its length or overflows
    assign phase_end = (CMP_BITS'(next_cnt) >= CMP_BITS'(phase_len)) || next_cnt[TICK_BITS];

    // Next state for one item
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_carrier = r_carrier;
        acc       = 1'b0;
        done      = 1'b0;
        if (i_command == CMD_START) begin
            if (!busy) begin
                n_shift   = build_frame(i_cfg.address_low, i_cfg.address_high,
                                        i_data_byte, i_cfg.trailer_byte);
                n_bit     = '0;
                n_cnt     = '0;
                n_phase   = PH_LEAD_MARK;
                n_carrier = 1'b1;
                acc       = 1'b1;
            end
        end else if (busy) begin
            if (phase_end) begin
                n_cnt = '0;
                case (r_phase)
                    PH_LEAD_MARK: begin
                        n_phase   = PH_LEAD_SPACE;
                        n_carrier = 1'b0;
                    end
                    PH_LEAD_SPACE: begin
                        n_phase   = PH_BIT_MARK;
                        n_carrier = 1'b1;
                    end
                    PH_BIT_MARK: begin
                        n_phase   = PH_BIT_SPACE;
                        n_carrier = 1'b0;
                    end
                    PH_BIT_SPACE: begin
                        n_shift   = r_shift >> 1;
                        n_bit     = next_bit[BIT_IDX_BITS-1:0];
                        n_phase   = (next_bit >= (BIT_IDX_BITS+1)'(FRAME_BITS)) ? PH_CLOSE
                                                                              : PH_BIT_MARK;
                        n_carrier = 1'b1;
                    end
                    default: begin
                        n_phase   = PH_IDLE;
                        n_carrier = 1'b0;
                        n_bit     = '0;
                        n_shift   = '0;
                        done      = 1'b1;
                    end
                endcase
            end else begin
                n_cnt = next_cnt[TICK_BITS-1:0];
            end
        end
    end

    // Result of this item, taken from the state it leaves
    assign o_result.carrier_on = n_carrier;
    assign o_result.busy_res   = (n_phase != PH_IDLE);
    assign o_result.accepted   = acc;
    assign o_result.frame_done = done;

    // Advance the state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_bit     <= '0;
            r_shift   <= '0;
            r_carrier <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_carrier <= n_carrier;
        end
    end

endmodule

// ===== sv/ipd_result_reg.sv =====
// Output register that holds a result item until the sink takes it.
module ipd_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ipd_pkg::t_result i_result,
    output logic             o_can_load,
    ipd_result_if.source     o_result
);
    import ipd_pkg::*;

    logic    r_valid;
    t_result r_data;

    // Take a new item when empty or when the held one leaves this cycle
    assign o_can_load = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload until the next load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.carrier_on = r_data.carrier_on;
    assign o_result.busy_res   = r_data.busy_res;
    assign o_result.accepted   = r_data.accepted;
    assign o_result.frame_done = r_data.frame_done;

endmodule

// ===== sv/ir_pulse_distance_frame_sender.sv =====
// Top level of the NEC-style infrared pulse-distance frame sender.
// The result of an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle while the result sink takes each result; state update and result load share a cycle.
// The input is ready whenever the result register is empty or being emptied.
// Reset (synchronous, active low) returns to idle, clears the frame state and
// restores every configuration register to its default.
module ir_pulse_distance_frame_sender (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ipd_item_if.sink                      i_item,
    ipd_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipd_pkg::PADDR_BITS-1:0] paddr,
    input  logic [ipd_pkg::PDATA_BITS-1:0] pwdata,
    output logic [ipd_pkg::PDATA_BITS-1:0] prdata,
    output logic                          pready
);
    import ipd_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    logic    can_load;
    logic    item_accept;

    assign i_item.ready = can_load;
    assign item_accept  = i_item.valid && can_load;

    ipd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ipd_frame_core u_frame_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (item_accept),
        .i_command   (i_item.command),
        .i_data_byte (i_item.data_byte),
        .i_cfg       (cfg),
        .o_result    (core_result)
    );

    ipd_result_reg u_result_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (item_accept),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

endmodule

// ===== sv/ipd_checker.sv =====
// Port-level checks of the frame sender, bound to the top level.
module ipd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic carrier_on,
    input logic busy_res,
    input logic accepted,
    input logic frame_done
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable({carrier_on, busy_res, accepted,
                                                          frame_done}))
        else $error("result item changed while stalled");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // Carrier is only on within a frame
    a_carrier_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && carrier_on |-> busy_res)
        else $error("carrier on outside a frame");

    // A frame end leaves the sender idle, and a new frame starts with the leader mark
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && frame_done |-> !busy_res && !carrier_on && !accepted)
        else $error("frame end not idle");

    a_start_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && accepted |-> busy_res && carrier_on)
        else $error("accepted frame did not start with the leader mark");

endmodule

bind ir_pulse_distance_frame_sender ipd_checker u_ipd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_ready   (i_item.ready),
    .out_valid  (o_result.valid),
    .out_ready  (o_result.ready),
    .carrier_on (o_result.carrier_on),
    .busy_res   (o_result.busy_res),
    .accepted   (o_result.accepted),
    .frame_done (o_result.frame_done)
);
